>>> src/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/hrgb_pkg.sv
// Shared widths, constants, sector codes and the divide-by-all-ones helper.
`timescale 1ns / 1ps

package hrgb_pkg;

  localparam int HUE_W  = 13;
  localparam int IN_W   = 16;
  localparam int DUTY_W = 16;
  localparam int REM_W  = 10;

  localparam logic [HUE_W-1:0]  HUE_FULL     = 13'd5760;
  localparam logic [HUE_W-1:0]  HUE_SECTOR   = 13'd960;
  localparam logic [DUTY_W-1:0] PERIOD_RESET = 16'd5000;

  // 60-degree sectors, in hue order
  typedef enum logic [2:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } sector_t;

  // floor(y / (2^k - 1)) by folding the high digit onto the low one.
  // Four folds bring any operand used here down to at most twice the divisor.
  function automatic logic [47:0] div_ones(input logic [47:0] y, input int unsigned k);
    logic [47:0] acc;
    logic [47:0] quo;
    logic [47:0] one;
    one = (48'd1 << k) - 48'd1;
    acc = y;
    quo = '0;
    for (int i = 0; i < 4; i++) begin
      quo = quo + (acc >> k);
      acc = (acc >> k) + (acc & one);
    end
    if (acc >= (one << 1)) begin
      quo = quo + 48'd2;
    end else if (acc >= one) begin
      quo = quo + 48'd1;
    end
    return quo;
  endfunction

endpackage

>>> src/hrgb_ifs.sv
// Valid/ready channel interfaces: color in, duty out, period write.
`timescale 1ns / 1ps

interface hrgb_color_if;
  import hrgb_pkg::*;
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [IN_W-1:0]   saturation;
  logic [IN_W-1:0]   brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hrgb_duty_if;
  import hrgb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] red_duty;
  logic [DUTY_W-1:0] green_duty;
  logic [DUTY_W-1:0] blue_duty;
  modport source (output valid, red_duty, green_duty, blue_duty, input ready);
  modport sink   (input valid, red_duty, green_duty, blue_duty, output ready);
endinterface

interface hrgb_cfg_if;
  import hrgb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> src/hrgb_front.sv
// Front end: out-of-range hue forced to zero, sector split and input rescale into one queue word.
`timescale 1ns / 1ps

module hrgb_front #(
  parameter int FRACTION_BITS = 16
) (
  hrgb_color_if.sink color,
  output logic                                  word_valid,
  input  logic                                  word_ready,
  output logic [1+3+hrgb_pkg::REM_W+2*FRACTION_BITS-1:0] word
);
  import hrgb_pkg::*;

  localparam int F = FRACTION_BITS;

  logic [HUE_W-1:0] hue_n;
  logic [HUE_W-1:0] base;
  sector_t          sector;
  logic [REM_W-1:0] rem;
  logic [47:0]      sat_scaled;
  logic [47:0]      bri_scaled;
  logic [47:0]      sat_q;
  logic [47:0]      bri_q;
  logic [F-1:0]     sat_f;
  logic [F-1:0]     bri_f;
  logic             grey;

  assign word_valid  = color.valid;
  assign color.ready = word_ready;

  always_comb begin
    hue_n = (color.hue >= HUE_FULL) ? '0 : color.hue;
    if (hue_n >= HUE_W'(5 * HUE_SECTOR)) begin
      sector = SECT_MR;
      base   = HUE_W'(5 * HUE_SECTOR);
    end else if (hue_n >= HUE_W'(4 * HUE_SECTOR)) begin
      sector = SECT_BM;
      base   = HUE_W'(4 * HUE_SECTOR);
    end else if (hue_n >= HUE_W'(3 * HUE_SECTOR)) begin
      sector = SECT_CB;
      base   = HUE_W'(3 * HUE_SECTOR);
    end else if (hue_n >= HUE_W'(2 * HUE_SECTOR)) begin
      sector = SECT_GC;
      base   = HUE_W'(2 * HUE_SECTOR);
    end else if (hue_n >= HUE_SECTOR) begin
      sector = SECT_YG;
      base   = HUE_SECTOR;
    end else begin
      sector = SECT_RY;
      base   = '0;
    end
    rem = REM_W'(hue_n - base);
  end

  // x * (2^F - 1) / 65535, the multiply done as shift and subtract
  assign sat_scaled = ({32'd0, color.saturation} << F) - {32'd0, color.saturation};
  assign bri_scaled = ({32'd0, color.brightness} << F) - {32'd0, color.brightness};
  assign sat_q      = div_ones(sat_scaled, IN_W);
  assign bri_q      = div_ones(bri_scaled, IN_W);
  assign sat_f      = sat_q[F-1:0];
  assign bri_f      = bri_q[F-1:0];
  assign grey       = (sat_f == '0);

  assign word = {grey, sector, rem, sat_f, bri_f};

endmodule

>>> src/hrgb_queue.sv
// Small register queue between the front and back ends.
`timescale 1ns / 1ps

module hrgb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= CW'(count + CW'(push) - CW'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

>>> src/hrgb_back.sv
// Back end: eight-stage blend and duty scaling pipeline, stalls as one.
`timescale 1ns / 1ps

module hrgb_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1+3+hrgb_pkg::REM_W+2*FRACTION_BITS-1:0] in_data,
  input  logic [hrgb_pkg::DUTY_W-1:0]           period,
  hrgb_duty_if.source                           duty
);
  import hrgb_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam logic [F-1:0] ONE = {F{1'b1}};
  // ceil(2^(F+8) / 15): exact divide by 15 for operands below 2^(F+4)
  localparam logic [F+4:0] RECIP = (F+5)'(((64'd1 << (F + 8)) + 64'd14) / 64'd15);

  logic             w_grey;
  logic [2:0]       w_sector;
  logic [REM_W-1:0] w_rem;
  logic [F-1:0]     w_s;
  logic [F-1:0]     w_v;

  assign {w_grey, w_sector, w_rem, w_s, w_v} = in_data;

  logic [7:0] vld;
  logic       adv;

  assign adv      = !vld[7] || duty.ready;
  assign in_ready = adv;

  // stage 1: rem * ONE / 64
  logic [F+9:0] rem_scaled;
  logic [F+3:0] s1_y;
  logic         s1_grey;
  sector_t      s1_sector;
  logic [F-1:0] s1_s, s1_v;

  // stage 2: reciprocal product, ff sits in its upper bits
  logic [2*F+8:0] ff_full;
  logic [2*F+7:0] s2_prod;
  logic           s2_grey;
  sector_t        s2_sector;
  logic [F-1:0]   s2_s, s2_v;

  // stage 3: s*ff, s*(1-ff), v*(1-s)
  logic [F-1:0]   ff;
  logic [2*F-1:0] s3_sff, s3_s1ff, s3_pp;
  logic           s3_grey;
  sector_t        s3_sector;
  logic [F-1:0]   s3_v;

  // stage 4: fold the three products
  logic [47:0]  sff_q, s1ff_q, p_q;
  logic [F-1:0] s4_sff, s4_s1ff, s4_p;
  logic         s4_grey;
  sector_t      s4_sector;
  logic [F-1:0] s4_v;

  // stage 5: v*(1-s*ff), v*(1-s*(1-ff))
  logic [2*F-1:0] s5_qp, s5_tp;
  logic [F-1:0]   s5_p;
  logic           s5_grey;
  sector_t        s5_sector;
  logic [F-1:0]   s5_v;

  // stage 6: fold q and t, pick channels by sector
  logic [47:0]  q_q, t_q;
  logic [F-1:0] q_f, t_f;
  logic [F-1:0] r_sel, g_sel, b_sel;
  logic [F-1:0] s6_r, s6_g, s6_b;

  // stage 7: period products
  logic [DUTY_W+F-1:0] s7_rd, s7_gd, s7_bd;

  // stage 8: fold and clamp to the period
  logic [47:0]       rd_q, gd_q, bd_q;
  logic [DUTY_W-1:0] r_duty, g_duty, b_duty;
  logic [DUTY_W-1:0] s8_r, s8_g, s8_b;

  assign rem_scaled = {w_rem, {F{1'b0}}} - (F+10)'(w_rem);
  assign ff_full    = s1_y * RECIP;
  assign ff         = s2_prod[2*F+7:F+8];

  assign sff_q  = div_ones(48'(s3_sff), F);
  assign s1ff_q = div_ones(48'(s3_s1ff), F);
  assign p_q    = div_ones(48'(s3_pp), F);

  assign q_q = div_ones(48'(s5_qp), F);
  assign t_q = div_ones(48'(s5_tp), F);
  assign q_f = q_q[F-1:0];
  assign t_f = t_q[F-1:0];

  always_comb begin
    unique case (s5_sector)
      SECT_RY: begin r_sel = s5_v; g_sel = t_f;  b_sel = s5_p; end
      SECT_YG: begin r_sel = q_f;  g_sel = s5_v; b_sel = s5_p; end
      SECT_GC: begin r_sel = s5_p; g_sel = s5_v; b_sel = t_f;  end
      SECT_CB: begin r_sel = s5_p; g_sel = q_f;  b_sel = s5_v; end
      SECT_BM: begin r_sel = t_f;  g_sel = s5_p; b_sel = s5_v; end
      default: begin r_sel = s5_v; g_sel = s5_p; b_sel = q_f;  end
    endcase
    if (s5_grey) begin
      r_sel = s5_v;
      g_sel = s5_v;
      b_sel = s5_v;
    end
  end

  assign rd_q   = div_ones(48'(s7_rd), F);
  assign gd_q   = div_ones(48'(s7_gd), F);
  assign bd_q   = div_ones(48'(s7_bd), F);
  assign r_duty = (rd_q > 48'(period)) ? period : rd_q[DUTY_W-1:0];
  assign g_duty = (gd_q > 48'(period)) ? period : gd_q[DUTY_W-1:0];
  assign b_duty = (bd_q > 48'(period)) ? period : bd_q[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_y      <= rem_scaled[F+9:6];
      s1_grey   <= w_grey;
      s1_sector <= sector_t'(w_sector);
      s1_s      <= w_s;
      s1_v      <= w_v;

      s2_prod   <= ff_full[2*F+7:0];
      s2_grey   <= s1_grey;
      s2_sector <= s1_sector;
      s2_s      <= s1_s;
      s2_v      <= s1_v;

      s3_sff    <= s2_s * ff;
      s3_s1ff   <= s2_s * (ONE - ff);
      s3_pp     <= s2_v * (ONE - s2_s);
      s3_grey   <= s2_grey;
      s3_sector <= s2_sector;
      s3_v      <= s2_v;

      s4_sff    <= sff_q[F-1:0];
      s4_s1ff   <= s1ff_q[F-1:0];
      s4_p      <= p_q[F-1:0];
      s4_grey   <= s3_grey;
      s4_sector <= s3_sector;
      s4_v      <= s3_v;

      s5_qp     <= s4_v * (ONE - s4_sff);
      s5_tp     <= s4_v * (ONE - s4_s1ff);
      s5_p      <= s4_p;
      s5_grey   <= s4_grey;
      s5_sector <= s4_sector;
      s5_v      <= s4_v;

      s6_r      <= r_sel;
      s6_g      <= g_sel;
      s6_b      <= b_sel;

      s7_rd     <= period * s6_r;
      s7_gd     <= period * s6_g;
      s7_bd     <= period * s6_b;

      s8_r      <= r_duty;
      s8_g      <= g_duty;
      s8_b      <= b_duty;
    end
  end

  assign duty.valid      = vld[7];
  assign duty.red_duty   = s8_r;
  assign duty.green_duty = s8_g;
  assign duty.blue_duty  = s8_b;

endmodule

>>> src/hsv_to_rgb_pwm_duty_top.sv
// HSV color to RGB PWM duty counts: each color word passes the combinational front end, the
// queue and the eight back-end stages before its duty word is valid.
// Sustains one color word per cycle while the output accepts; the rate is set by the eight-stage
// multiply/fold pipeline in the back end, which stalls as a unit on the output.
// A queue of QUEUE_DEPTH words lets the input keep accepting while a result waits.
// Reset (rst, synchronous) empties the queue and pipeline and sets the period to 5000.
`timescale 1ns / 1ps

module hsv_to_rgb_pwm_duty_top #(
  parameter int FRACTION_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst,
  hrgb_color_if.sink  color,
  hrgb_duty_if.source duty,
  hrgb_cfg_if.sink    cfg
);
  import hrgb_pkg::*;

  localparam int WORD_W = 1 + 3 + REM_W + 2 * FRACTION_BITS;

  logic [DUTY_W-1:0] duty_period;

  logic              fq_valid, fq_ready;
  logic [WORD_W-1:0] fq_word;
  logic              qb_valid, qb_ready;
  logic [WORD_W-1:0] qb_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_period <= PERIOD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      duty_period <= cfg.data;
    end
  end

  hrgb_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .color      (color),
    .word_valid (fq_valid),
    .word_ready (fq_ready),
    .word       (fq_word)
  );

  hrgb_queue #(
    .WIDTH(WORD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_word),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_word)
  );

  hrgb_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (qb_valid),
    .in_ready (qb_ready),
    .in_data  (qb_word),
    .period   (duty_period),
    .duty     (duty)
  );

endmodule

>>> src/hrgb_checker.sv
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrgb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         color_valid,
  input logic                         color_ready,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [hrgb_pkg::DUTY_W-1:0]  cfg_data,
  input logic                         duty_valid,
  input logic                         duty_ready,
  input logic [hrgb_pkg::DUTY_W-1:0]  red,
  input logic [hrgb_pkg::DUTY_W-1:0]  green,
  input logic [hrgb_pkg::DUTY_W-1:0]  blue
);
  import hrgb_pkg::*;

  logic [7:0]        outstanding;
  logic [DUTY_W-1:0] peak_period;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = color_valid && color_ready;
  assign out_acc = duty_valid && duty_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      peak_period <= PERIOD_RESET;
    end else begin
      outstanding <= outstanding + 8'(in_acc) - 8'(out_acc);
      if (cfg_valid && cfg_ready && (cfg_data > peak_period)) begin
        peak_period <= cfg_data;
      end
    end
  end

  `ASSERT_NEXT(a_duty_hold, clk, rst, duty_valid && !duty_ready, duty_valid && $stable(red) && $stable(green) && $stable(blue), "duty word changed while stalled")

  `ASSERT_IMPL(a_no_extra_word, clk, rst, duty_valid, outstanding != 8'd0, "duty word without a color word in flight")

  `ASSERT_IMPL(a_duty_in_range, clk, rst, duty_valid, (red <= peak_period) && (green <= peak_period) && (blue <= peak_period), "duty above any written period")

endmodule

bind hsv_to_rgb_pwm_duty_top hrgb_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .color_valid (color.valid),
  .color_ready (color.ready),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready),
  .cfg_data    (cfg.data),
  .duty_valid  (duty.valid),
  .duty_ready  (duty.ready),
  .red         (duty.red_duty),
  .green       (duty.green_duty),
  .blue        (duty.blue_duty)
);
